// ===== hdl/tlsc_pkg.sv =====
// Types, constants and arithmetic helpers shared by the tilt leveling servo controller.
package tlsc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SCALE_SHIFT = 24 - SAMPLE_BITS;

    // CORDIC datapath widths: x/y hold scaled samples with growth, z holds 2^-16 degree.
    localparam int XW = 27;
    localparam int ZW = 26;
    // Angle arithmetic width in 1/256 degree, with room for differences.
    localparam int AW = 19;
    localparam int MBW = 18;
    localparam int PW = XW + MBW;
    localparam int TAB_IW = 5;
    localparam int ATAN_LEN = 24;

    localparam logic [16:0] INV_GAIN_Q16 = 17'd39797;
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(90 * 65536);

    localparam logic [2:0] CFG_ROLL_OFFSET    = 3'd0;
    localparam logic [2:0] CFG_SLEW_LIMIT     = 3'd1;
    localparam logic [2:0] CFG_DEADBAND       = 3'd2;
    localparam logic [2:0] CFG_SERVO_GAIN     = 3'd3;
    localparam logic [2:0] CFG_SERVO_CENTER   = 3'd4;
    localparam logic [2:0] CFG_TOUCH_THRESHOLD = 3'd5;

    localparam logic signed [12:0] RST_ROLL_OFFSET = 13'sd768;
    localparam logic [13:0] RST_SLEW_LIMIT = 14'd1024;
    localparam logic [11:0] RST_DEADBAND = 12'd256;
    localparam logic [11:0] RST_SERVO_GAIN = 12'd800;
    localparam logic [15:0] RST_SERVO_CENTER = 16'd32768;
    localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd52429;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROLL_ITER,
        ST_ROLL_END,
        ST_PITCH_LOAD,
        ST_PITCH_ITER,
        ST_PITCH_END,
        ST_SERVO_P,
        ST_SERVO_PW,
        ST_SERVO_RW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic [15:0]                   touch_level;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic [15:0]        roll_servo;
        logic [15:0]        pitch_servo;
        logic               roll_updated;
        logic               pitch_updated;
        logic               leveling_on;
    } out_item_t;

    // Rounded atan(2^-i) in 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [TAB_IW-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = ZW'(2949120);
            5'd1:  v = ZW'(1740967);
            5'd2:  v = ZW'(919879);
            5'd3:  v = ZW'(466945);
            5'd4:  v = ZW'(234379);
            5'd5:  v = ZW'(117304);
            5'd6:  v = ZW'(58666);
            5'd7:  v = ZW'(29335);
            5'd8:  v = ZW'(14668);
            5'd9:  v = ZW'(7334);
            5'd10: v = ZW'(3667);
            5'd11: v = ZW'(1833);
            5'd12: v = ZW'(917);
            5'd13: v = ZW'(458);
            5'd14: v = ZW'(229);
            5'd15: v = ZW'(115);
            5'd16: v = ZW'(57);
            5'd17: v = ZW'(29);
            5'd18: v = ZW'(14);
            5'd19: v = ZW'(7);
            5'd20: v = ZW'(4);
            5'd21: v = ZW'(2);
            5'd22: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // A step of limit or more is clamped to last plus or minus the limit.
    function automatic logic signed [AW-1:0] slew_clamp(input logic signed [AW-1:0] last,
                                                        input logic signed [AW-1:0] now,
                                                        input logic [13:0] limit);
        logic signed [AW-1:0] d;
        logic signed [AW-1:0] ad;
        logic signed [AW-1:0] lim;
        logic signed [AW-1:0] r;
        d = now - last;
        ad = d[AW-1] ? -d : d;
        lim = AW'($signed({1'b0, limit}));
        if (ad >= lim) begin
            r = (d > 0) ? last + lim : last - lim;
        end else begin
            r = now;
        end
        return r;
    endfunction

    // Center minus the rounded gain term, saturated to the 16-bit command range.
    function automatic logic [15:0] servo_cmd(input logic signed [PW-1:0] prod,
                                              input logic [15:0] center);
        logic signed [PW-1:0] psum;
        logic signed [29:0] term;
        logic signed [30:0] c;
        logic [15:0] r;
        psum = prod + PW'(128);
        term = psum[37:8];
        c = 31'($signed({1'b0, center})) - 31'(term);
        if (c < 0) begin
            r = 16'd0;
        end else if (c > 31'sd65535) begin
            r = 16'hFFFF;
        end else begin
            r = c[15:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/tilt_leveling_servo_controller.sv =====
// Tilt leveling servo controller: iterated CORDIC for roll and pitch, slew limit and servo law.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------------------------------
//  in       | input     | in_valid / in_stall | in_data  (accel x/y/z, touch level)
//  out      | output    | out_valid/out_stall | out_data (angles, servo commands)
//  cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A result is written to the output register after its request has run through the roll and
// pitch rotations and the servo states; no new request is taken until the previous one has left
// its done state, as the one CORDIC rotator serves roll then pitch and one multiplier all products.
// Reset restores configuration, block state and control; datapath registers need no reset.
// A stalled result is held in the output register; the next request still runs up to its
// final cycle, where it waits until the output register is free.
module tilt_leveling_servo_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tlsc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tlsc_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int XW = tlsc_pkg::XW;
    localparam int ZW = tlsc_pkg::ZW;
    localparam int AW = tlsc_pkg::AW;
    localparam int PW = tlsc_pkg::PW;
    localparam int MBW = tlsc_pkg::MBW;

    tlsc_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic signed [12:0] roll_offset_reg;
    logic [13:0]        slew_limit_reg;
    logic [11:0]        deadband_reg;
    logic [11:0]        servo_gain_reg;
    logic [15:0]        servo_center_reg;
    logic [15:0]        touch_threshold_reg;

    // Block state.
    logic signed [16:0] last_roll_reg;
    logic signed [16:0] last_pitch_reg;
    logic [15:0]        roll_position_reg;
    logic [15:0]        pitch_position_reg;
    logic               touch_armed_reg;
    logic               leveling_reg;
    logic               roll_upd_reg;
    logic               pitch_upd_reg;

    // Datapath.
    tlsc_pkg::in_item_t   in_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] roll_now_reg;

    logic                out_valid_reg;
    tlsc_pkg::out_item_t out_reg;

    logic accept;
    logic out_free;
    logic last_step;

    // Loader with left half plane pre-rotation.
    logic                 load_en;
    logic signed [XW-1:0] ld_x, ld_y;
    logic signed [XW-1:0] lx_next, ly_next;
    logic signed [ZW-1:0] lz_next;

    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] step_angle;

    logic signed [MBW-1:0] mul_b;
    logic signed [XW-1:0]  mul_a;
    logic signed [PW-1:0]  mag_sum;
    logic signed [XW-1:0]  mag;
    logic signed [ZW-1:0]  z_round;
    logic signed [AW-1:0]  angle_now;
    logic signed [AW-1:0]  roll_slewed, pitch_slewed;
    logic                  touch_hit, touch_high;
    logic [16:0]           abs_roll, abs_pitch;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != tlsc_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_step = (cnt_reg == CW'(CORDIC_STEPS - 1));
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= tlsc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_en = 1'b0;
        unique case (state_reg)
            tlsc_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = tlsc_pkg::ST_ROLL_ITER;
                    load_en = 1'b1;
                end
            end
            tlsc_pkg::ST_ROLL_ITER: begin
                if (last_step) begin
                    state_next = tlsc_pkg::ST_ROLL_END;
                end
            end
            tlsc_pkg::ST_ROLL_END:   state_next = tlsc_pkg::ST_PITCH_LOAD;
            tlsc_pkg::ST_PITCH_LOAD: begin
                state_next = tlsc_pkg::ST_PITCH_ITER;
                load_en = 1'b1;
            end
            tlsc_pkg::ST_PITCH_ITER: begin
                if (last_step) begin
                    state_next = tlsc_pkg::ST_PITCH_END;
                end
            end
            tlsc_pkg::ST_PITCH_END:  state_next = tlsc_pkg::ST_SERVO_P;
            tlsc_pkg::ST_SERVO_P:    state_next = tlsc_pkg::ST_SERVO_PW;
            tlsc_pkg::ST_SERVO_PW:   state_next = tlsc_pkg::ST_SERVO_RW;
            tlsc_pkg::ST_SERVO_RW:   state_next = tlsc_pkg::ST_DONE;
            tlsc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tlsc_pkg::ST_IDLE;
                end
            end
            default: state_next = tlsc_pkg::ST_IDLE;
        endcase
    end

    // Roll starts from (az, ay); pitch from (scaled magnitude, -ax).
    always_comb begin
        if (state_reg == tlsc_pkg::ST_IDLE) begin
            ld_x = XW'(24'(in_data.accel_z) <<< tlsc_pkg::SCALE_SHIFT);
            ld_y = XW'(24'(in_data.accel_y) <<< tlsc_pkg::SCALE_SHIFT);
        end else begin
            ld_x = mag;
            ld_y = -XW'(24'(in_reg.accel_x) <<< tlsc_pkg::SCALE_SHIFT);
        end
        lx_next = ld_x;
        ly_next = ld_y;
        lz_next = '0;
        if (ld_x < 0) begin
            if (ld_y >= 0) begin
                lx_next = ld_y;
                ly_next = -ld_x;
                lz_next = tlsc_pkg::QUARTER_TURN;
            end else begin
                lx_next = -ld_y;
                ly_next = ld_x;
                lz_next = -tlsc_pkg::QUARTER_TURN;
            end
        end
    end

    assign dx = y_reg >>> cnt_reg;
    assign dy = x_reg >>> cnt_reg;
    assign step_angle = tlsc_pkg::atan_lut(tlsc_pkg::TAB_IW'(cnt_reg));

    // Shared multiplier: 1/K correction of the roll magnitude, then the two servo terms.
    always_comb begin
        if (state_reg == tlsc_pkg::ST_ROLL_END) begin
            mul_a = x_reg;
            mul_b = MBW'($signed({1'b0, tlsc_pkg::INV_GAIN_Q16}));
        end else begin
            mul_a = XW'($signed({1'b0, servo_gain_reg}));
            if (state_reg == tlsc_pkg::ST_SERVO_P) begin
                mul_b = MBW'(last_pitch_reg);
            end else begin
                mul_b = MBW'(last_roll_reg);
            end
        end
    end

    assign mag_sum   = prod_reg + PW'(32768);
    assign mag       = XW'(mag_sum >>> 16);
    assign z_round   = z_reg + ZW'(128);
    assign angle_now = AW'(z_round >>> 8);

    assign roll_slewed  = tlsc_pkg::slew_clamp(AW'(last_roll_reg), roll_now_reg, slew_limit_reg);
    assign pitch_slewed = tlsc_pkg::slew_clamp(AW'(last_pitch_reg), angle_now, slew_limit_reg);

    assign touch_hit  = touch_armed_reg && (in_reg.touch_level <= touch_threshold_reg);
    assign touch_high = (in_reg.touch_level >= touch_threshold_reg);

    assign abs_roll  = last_roll_reg[16] ? 17'(-last_roll_reg) : 17'(last_roll_reg);
    assign abs_pitch = last_pitch_reg[16] ? 17'(-last_pitch_reg) : 17'(last_pitch_reg);

    // Datapath registers without reset.
    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;
        if (accept) begin
            in_reg <= in_data;
        end
        if (load_en) begin
            x_reg <= lx_next;
            y_reg <= ly_next;
            z_reg <= lz_next;
        end else if (state_reg == tlsc_pkg::ST_ROLL_ITER ||
                     state_reg == tlsc_pkg::ST_PITCH_ITER) begin
            if (y_reg > 0) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + step_angle;
            end else if (y_reg < 0) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - step_angle;
            end
        end
        if (state_reg == tlsc_pkg::ST_ROLL_END) begin
            roll_now_reg <= angle_now + AW'(roll_offset_reg);
        end
        if (state_reg == tlsc_pkg::ST_DONE && out_free) begin
            out_reg.roll_angle    <= last_roll_reg;
            out_reg.pitch_angle   <= last_pitch_reg[15:0];
            out_reg.roll_servo    <= roll_position_reg;
            out_reg.pitch_servo   <= pitch_position_reg;
            out_reg.roll_updated  <= roll_upd_reg;
            out_reg.pitch_updated <= pitch_upd_reg;
            out_reg.leveling_on   <= leveling_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else if (load_en) begin
            cnt_reg <= '0;
        end else if (state_reg == tlsc_pkg::ST_ROLL_ITER ||
                     state_reg == tlsc_pkg::ST_PITCH_ITER) begin
            cnt_reg <= last_step ? '0 : cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            roll_offset_reg     <= tlsc_pkg::RST_ROLL_OFFSET;
            slew_limit_reg      <= tlsc_pkg::RST_SLEW_LIMIT;
            deadband_reg        <= tlsc_pkg::RST_DEADBAND;
            servo_gain_reg      <= tlsc_pkg::RST_SERVO_GAIN;
            servo_center_reg    <= tlsc_pkg::RST_SERVO_CENTER;
            touch_threshold_reg <= tlsc_pkg::RST_TOUCH_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tlsc_pkg::CFG_ROLL_OFFSET:     roll_offset_reg     <= cfg_data[12:0];
                tlsc_pkg::CFG_SLEW_LIMIT:      slew_limit_reg      <= cfg_data[13:0];
                tlsc_pkg::CFG_DEADBAND:        deadband_reg        <= cfg_data[11:0];
                tlsc_pkg::CFG_SERVO_GAIN:      servo_gain_reg      <= cfg_data[11:0];
                tlsc_pkg::CFG_SERVO_CENTER:    servo_center_reg    <= cfg_data;
                tlsc_pkg::CFG_TOUCH_THRESHOLD: touch_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            last_roll_reg      <= '0;
            last_pitch_reg     <= '0;
            roll_position_reg  <= tlsc_pkg::RST_SERVO_CENTER;
            pitch_position_reg <= tlsc_pkg::RST_SERVO_CENTER;
            touch_armed_reg    <= 1'b0;
            leveling_reg       <= 1'b1;
            roll_upd_reg       <= 1'b0;
            pitch_upd_reg      <= 1'b0;
        end else begin
            case (state_reg)
                tlsc_pkg::ST_PITCH_END: begin
                    last_roll_reg  <= 17'(roll_slewed);
                    last_pitch_reg <= 17'(pitch_slewed);
                    if (touch_hit) begin
                        touch_armed_reg <= 1'b0;
                        leveling_reg    <= !leveling_reg;
                    end else if (touch_high) begin
                        touch_armed_reg <= 1'b1;
                    end
                end
                tlsc_pkg::ST_SERVO_PW: begin
                    pitch_upd_reg <= leveling_reg && (abs_pitch >= 17'(deadband_reg));
                    if (leveling_reg && (abs_pitch >= 17'(deadband_reg))) begin
                        pitch_position_reg <= tlsc_pkg::servo_cmd(prod_reg, servo_center_reg);
                    end
                end
                tlsc_pkg::ST_SERVO_RW: begin
                    roll_upd_reg <= leveling_reg && (abs_roll >= 17'(deadband_reg));
                    if (leveling_reg && (abs_roll >= 17'(deadband_reg))) begin
                        roll_position_reg <= tlsc_pkg::servo_cmd(prod_reg, servo_center_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == tlsc_pkg::ST_DONE && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // A servo load can only be reported while leveling is on.
    a_update_needs_leveling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.leveling_on ||
                       !(out_data.roll_updated || out_data.pitch_updated)))
        else $error("servo update reported with leveling off");

    // The rotator never drives x negative once the pre-rotation is done.
    a_cordic_x_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tlsc_pkg::ST_ROLL_ITER || state_reg == tlsc_pkg::ST_PITCH_ITER)
        |-> !x_reg[XW-1])
        else $error("CORDIC x went negative");

    // An accepted request starts the roll iterations from the first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == tlsc_pkg::ST_ROLL_ITER && cnt_reg == '0))
        else $error("accepted request did not start the rotator");

endmodule
